// ===== hdl/ltp_pkg.sv =====
`timescale 1ns / 1ps

package ltp_pkg;

	localparam int TS_W      = 32;
	localparam int CLK_HZ_W  = 32;
	localparam int CPU_W     = 13;
	localparam int LAT_W     = 32;
	localparam int RATE_W    = 16;
	localparam int CNT_W     = 32;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 32;
	localparam int DIV_W     = 32;
	localparam int OUT_W     = LAT_W + RATE_W + CNT_W;

	localparam logic [CLK_HZ_W-1:0] CLOCK_HZ_RESET      = 32'd180000000;
	localparam logic [CPU_W-1:0]    CYCLES_PER_US_RESET = 13'd180;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HZ      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CYCLES_PER_US = 1'd1;

	// event kinds carried on s_tuser
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_STOP  = 1'b1;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] num;
		logic [DIV_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
	} div_rsp_t;

endpackage

// ===== hdl/latency_throughput_profiler_top.sv =====
`timescale 1ns / 1ps

// Latency / throughput profiler.
// Input stream: s_tuser is the event kind (0 start, 1 stop), s_tdata the 32-bit
// cycle timestamp. Every input beat produces one output beat carrying the last
// latency in microseconds, the throughput (clock_hz over average cycles, low
// 16 bits) and the wrapping count of completed measurements.
// A start beat goes through S_OUT into the output register. A stop beat runs
// up to three 32-bit divisions in turn on one shared bit-serial divider:
// elapsed / cycles_per_us, total / count, clock_hz / average. One item at a
// time: s_tready is high only while the sequencer is idle.
// The result waits in an output register; while the receiver stalls, the next
// input beat is still taken and processed, and the sequencer holds before
// writing its result until the register has been emptied.
// The user writes configuration (cfg_we, cfg_index, cfg_wdata) only while idle;
// the block does not enforce it. Index 0 is clock_hz, index 1 is cycles_per_us
// (low 13 bits kept). Reset clears all counters and results, restores default config.
module latency_throughput_profiler_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [ltp_pkg::TS_W-1:0]           s_tdata,   // timestamp
	input  logic                               s_tuser,   // action
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [ltp_pkg::OUT_W-1:0]          m_tdata,   // latency, throughput, event_count
	input  logic                               cfg_we,
	input  logic [ltp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ltp_pkg::CFG_DAT_W-1:0]      cfg_wdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LAT,
		S_AVG,
		S_RATE,
		S_OUT
	} state_t;

	state_t state_q;

	logic [ltp_pkg::CLK_HZ_W-1:0] clock_hz_q;
	logic [ltp_pkg::CPU_W-1:0]    cycles_per_us_q;
	logic [ltp_pkg::TS_W-1:0]     start_time_q;
	logic [ltp_pkg::CNT_W-1:0]    count_q;
	logic [ltp_pkg::DIV_W-1:0]    total_q;
	logic [ltp_pkg::LAT_W-1:0]    latency_q;
	logic [ltp_pkg::RATE_W-1:0]   rate_q;
	logic                         m_valid_q;
	logic [ltp_pkg::OUT_W-1:0]    m_data_q;

	ltp_pkg::div_req_t div_req;
	ltp_pkg::div_rsp_t div_rsp;

	logic                      in_beat;
	logic [ltp_pkg::TS_W-1:0]  elapsed;
	logic [ltp_pkg::CNT_W-1:0] count_nx;
	logic [ltp_pkg::DIV_W-1:0] total_nx;
	logic                      out_free;

	assign s_tready = (state_q == S_IDLE);
	assign in_beat  = s_tvalid && s_tready;
	assign elapsed  = s_tdata - start_time_q;
	assign count_nx = count_q + 1'b1;
	assign total_nx = total_q + elapsed;
	assign out_free = !m_valid_q || m_tready;

	// divider issue: at most one request per state transition, only into S_LAT, S_AVG or S_RATE
	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = elapsed;
		div_req.den   = {{(ltp_pkg::DIV_W - ltp_pkg::CPU_W){1'b0}}, cycles_per_us_q};
		unique case (state_q)
			S_IDLE: begin
				div_req.start = in_beat && (s_tuser == ltp_pkg::ACT_STOP);
			end
			S_LAT: begin
				div_req.num   = total_q;
				div_req.den   = count_q;
				div_req.start = div_rsp.done && (total_q != '0) && (count_q != '0);
			end
			S_AVG: begin
				div_req.num   = clock_hz_q;
				div_req.den   = div_rsp.quot;
				div_req.start = div_rsp.done && (div_rsp.quot != '0);
			end
			S_RATE, S_OUT: begin
				div_req.start = 1'b0;
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	ltp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			clock_hz_q      <= ltp_pkg::CLOCK_HZ_RESET;
			cycles_per_us_q <= ltp_pkg::CYCLES_PER_US_RESET;
			start_time_q    <= '0;
			count_q         <= '0;
			total_q         <= '0;
			latency_q       <= '0;
			rate_q          <= '0;
			m_valid_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					ltp_pkg::REG_CLOCK_HZ:      clock_hz_q <= cfg_wdata;
					ltp_pkg::REG_CYCLES_PER_US: cycles_per_us_q <= cfg_wdata[ltp_pkg::CPU_W-1:0];
					default: ;
				endcase
			end

			// load wins over drain: the register is free whenever a load happens
			if (state_q == S_OUT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						if (s_tuser == ltp_pkg::ACT_STOP) begin
							count_q <= count_nx;
							total_q <= total_nx;
							state_q <= S_LAT;
						end else begin
							start_time_q <= s_tdata;
							state_q      <= S_OUT;
						end
					end
				end
				S_LAT: begin
					if (div_rsp.done) begin
						latency_q <= div_rsp.quot;
						state_q   <= div_req.start ? S_AVG : S_OUT;
					end
				end
				S_AVG: begin
					if (div_rsp.done) begin
						state_q <= div_req.start ? S_RATE : S_OUT;
					end
				end
				S_RATE: begin
					if (div_rsp.done) begin
						rate_q  <= div_rsp.quot[ltp_pkg::RATE_W-1:0];
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			m_data_q <= {count_q, rate_q, latency_q};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

// ===== hdl/ltp_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. A zero divisor yields all ones.
module ltp_div (
	input  logic               clk,
	input  logic               arst_n,
	input  ltp_pkg::div_req_t  req,
	output ltp_pkg::div_rsp_t  rsp
);

	localparam int W     = ltp_pkg::DIV_W;
	localparam int STEP_W = $clog2(W);

	logic [W-1:0]      rem_q;
	logic [W-1:0]      quo_q;
	logic [W-1:0]      den_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	logic [W:0] trial;
	logic [W:0] diff;
	logic       ge;

	assign trial = {rem_q, quo_q[W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

// ===== hdl/ltp_checker.sv =====
`timescale 1ns / 1ps

module ltp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [ltp_pkg::OUT_W-1:0]     m_tdata
);

	// no second beat taken while one is in work
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	// a stop beat occupies the divider and holds s_tready low while it works
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == ltp_pkg::ACT_STOP) |=> ##1 !s_tready)
		else $error("stop beat finished too early");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat dropped under stall");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("output beat changed under stall");

endmodule

bind latency_throughput_profiler_top ltp_checker u_ltp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
